// File: hw/rtl/assert_macros.svh
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/bn8_pkg.sv
// shared types, constants and helpers for the int8 batch normalisation block
`default_nettype none
package bn8_pkg;

    localparam int BN8_LANES      = 8;
    localparam int BN8_MAX_GROUPS = 256;

    localparam logic [2:0] CFG_GROUP_LENGTH = 3'd0;
    localparam logic [2:0] CFG_RUN_LENGTH   = 3'd1;
    localparam logic [2:0] CFG_RELU_ENABLE  = 3'd2;
    localparam logic [2:0] CFG_INPUT_SCALE  = 3'd3;
    localparam logic [2:0] CFG_OUTPUT_SCALE = 3'd4;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [1:0] TBL_MEAN    = 2'd0;
    localparam logic [1:0] TBL_INV_STD = 2'd1;
    localparam logic [1:0] TBL_GAMMA   = 2'd2;
    localparam logic [1:0] TBL_BETA    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M1,
        ST_SUB,
        ST_M2,
        ST_N,
        ST_M3,
        ST_ADD,
        ST_M4,
        ST_O,
        ST_RND
    } bn8_state_t;

    typedef struct packed {
        bn8_state_t step;
        logic       relu;
    } bn8_ctrl_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bn8_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module bn8_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/bn8_lane.sv
// one lane datapath: shared multiplier stepped through the normalisation chain
`default_nettype none
module bn8_lane (
    input  wire logic               clk,
    input  wire bn8_pkg::bn8_ctrl_t ctrl,
    input  wire logic signed [7:0]  x,
    input  wire logic signed [31:0] in_scale,
    input  wire logic signed [31:0] out_scale,
    input  wire logic signed [31:0] mean,
    input  wire logic signed [31:0] inv_std,
    input  wire logic signed [31:0] gamma,
    input  wire logic signed [31:0] beta,
    output logic             [7:0]  result
);
    import bn8_pkg::*;

    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] v_reg, v_next;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic signed [63:0] shifted;
    logic signed [31:0] a_sat;
    logic        [32:0] mag;
    logic        [33:0] rsum;
    logic        [17:0] rint;

    always_comb
    begin
        mul_a = (ctrl.step == ST_M1) ? 32'(x) : v_reg;
        case (ctrl.step)
            ST_M1:   mul_b = in_scale;
            ST_M2:   mul_b = inv_std;
            ST_M3:   mul_b = gamma;
            ST_M4:   mul_b = out_scale;
            default: mul_b = in_scale;
        endcase
        prod    = mul_a * mul_b;
        shifted = acc_reg >>> 16;
        a_sat   = sat32(acc_reg);
    end

    always_comb
    begin
        acc_next = acc_reg;
        v_next   = v_reg;
        case (ctrl.step)
            ST_M1, ST_M2, ST_M3, ST_M4: acc_next = prod;
            ST_SUB:       v_next = sat32(64'(a_sat) - 64'(mean));
            ST_N, ST_O:   v_next = sat32(shifted);
            ST_ADD:       v_next = sat32(shifted + 64'(beta));
            default:      v_next = v_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        v_reg   <= v_next;
    end

    // round half away from zero on magnitude, clamp to int8; relu zeroes negatives
    always_comb
    begin
        mag  = v_reg[31] ? (~{v_reg[31], v_reg} + 33'd1) : {1'b0, v_reg};
        rsum = 34'(mag) + 34'h8000;
        rint = rsum[33:16];
        if (!v_reg[31])
            result = (rint > 18'd127) ? 8'h7f : rint[7:0];
        else if (ctrl.relu)
            result = 8'h00;
        else
            result = (rint > 18'd128) ? 8'h80 : (~rint[7:0] + 8'd1);
    end
endmodule
`default_nettype wire

// File: hw/rtl/batch_norm_int8_lanes.sv
// top level: int8 lane batch normalisation with per-lane parameter tables
//
// input channel (in_valid/in_stall) carries either a data word of packed
// signed int8 lanes or a parameter load (operation = 1) that writes one
// 32-bit Q16.16 entry of the mean, inverse std, gamma or beta table.
// a load leaves the sequencer idle and gives no result.
// a data word reads the lane parameters of the current group from the table
// rams and steps each lane's single multiplier through the nine-step
// normalisation chain; the result is registered on the output channel
// (out_valid/out_stall) from the final step, and input stalls until then.
// while a result waits under out_stall the next item is still accepted;
// the following data word then holds in its final step until the output
// register frees up. reset sets the group and run counters, the sequencer,
// out_valid and the configuration registers to defaults; table contents
// are undefined until loaded, there is no clearing pass. configuration is
// written through cfg_write/cfg_index/cfg_data; the user must write it only
// while idle, the block itself does not enforce this.
`default_nettype none
module batch_norm_int8_lanes #(
    parameter int LANES      = bn8_pkg::BN8_LANES,
    parameter int MAX_GROUPS = bn8_pkg::BN8_MAX_GROUPS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [63:0] data_lanes,
    input  wire logic [1:0]  table_select,
    input  wire logic [7:0]  group_index,
    input  wire logic [2:0]  lane_index,
    input  wire logic signed [31:0] param_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [63:0] result_lanes,
    output logic             run_done
);
    import bn8_pkg::*;

    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    logic [15:0]        group_length_reg;
    logic [23:0]        run_length_reg;
    logic               relu_enable_reg;
    logic signed [31:0] input_scale_reg;
    logic signed [31:0] output_scale_reg;

    bn8_state_t state_reg, state_next;
    logic [GW-1:0] group_reg, group_next;
    logic [15:0]   gpos_reg, gpos_next;
    logic [23:0]   rpos_reg, rpos_next;
    logic [63:0]   data_reg;
    logic          done_reg;
    logic          done_next;
    logic          out_valid_reg;
    logic [63:0]   result_reg;
    logic          run_done_reg;

    logic          accept, data_accept, load_accept, out_load;
    logic          load_in_range;
    logic [16:0]   gpos_inc;
    logic [24:0]   rpos_inc;
    logic [GW+7:0] gidx_ext;
    logic [GW-1:0] waddr;
    logic [63:0]   lane_word;
    bn8_ctrl_t     ctrl;

    assign accept      = in_valid && !in_stall;
    assign data_accept = accept && (operation == OP_DATA);
    assign load_accept = accept && (operation == OP_LOAD);
    assign load_in_range = (32'(group_index) < 32'(MAX_GROUPS)) &&
                           (32'(lane_index) < 32'(LANES));
    assign gidx_ext    = {{GW{1'b0}}, group_index};
    assign waddr       = gidx_ext[GW-1:0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_length_reg <= 16'd1;
            run_length_reg   <= 24'd1;
            relu_enable_reg  <= 1'b0;
            input_scale_reg  <= 32'sd65536;
            output_scale_reg <= 32'sd65536;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_GROUP_LENGTH: group_length_reg <= cfg_data[15:0];
                CFG_RUN_LENGTH:   run_length_reg   <= cfg_data[23:0];
                CFG_RELU_ENABLE:  relu_enable_reg  <= cfg_data[0];
                CFG_INPUT_SCALE:  input_scale_reg  <= cfg_data;
                CFG_OUTPUT_SCALE: output_scale_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // group and run position, advanced when a data word is taken
    always_comb
    begin
        gpos_inc   = 17'(gpos_reg) + 17'd1;
        rpos_inc   = 25'(rpos_reg) + 25'd1;
        group_next = group_reg;
        gpos_next  = gpos_reg;
        rpos_next  = rpos_reg;
        done_next  = done_reg;
        if (data_accept)
        begin
            if (gpos_inc >= 17'(group_length_reg))
            begin
                gpos_next  = 16'd0;
                group_next = (group_reg == GW'(MAX_GROUPS - 1)) ? '0 : group_reg + 1'b1;
            end
            else
            begin
                gpos_next = gpos_inc[15:0];
            end
            rpos_next = rpos_inc[23:0];
            done_next = rpos_inc >= 25'(run_length_reg);
            if (done_next)
            begin
                rpos_next  = 24'd0;
                gpos_next  = 16'd0;
                group_next = '0;
            end
        end
    end

    // sequencer next state
    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = data_accept ? ST_M1 : ST_IDLE;
            ST_M1:   state_next = ST_SUB;
            ST_SUB:  state_next = ST_M2;
            ST_M2:   state_next = ST_N;
            ST_N:    state_next = ST_M3;
            ST_M3:   state_next = ST_ADD;
            ST_ADD:  state_next = ST_M4;
            ST_M4:   state_next = ST_O;
            ST_O:    state_next = ST_RND;
            ST_RND:  state_next = out_load ? ST_IDLE : ST_RND;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_load  = (state_reg == ST_RND) && (!out_valid_reg || !out_stall);
        ctrl.step = state_reg;
        ctrl.relu = relu_enable_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            group_reg     <= '0;
            gpos_reg      <= 16'd0;
            rpos_reg      <= 24'd0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            group_reg <= group_next;
            gpos_reg  <= gpos_next;
            rpos_reg  <= rpos_next;
            done_reg  <= done_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_accept)
            data_reg <= data_lanes;
        if (out_load)
        begin
            result_reg   <= lane_word;
            run_done_reg <= done_reg;
        end
    end

    // per-lane tables and datapaths
    for (genvar l = 0; l < 8; l++)
    begin : g_lane
        if (l < LANES)
        begin : g_used
            logic [31:0] tdata [4];
            logic [7:0]  lres;

            for (genvar t = 0; t < 4; t++)
            begin : g_tbl
                logic we;
                assign we = load_accept && load_in_range &&
                            (lane_index == 3'(l)) && (table_select == 2'(t));
                bn8_ram #(
                    .WIDTH (32),
                    .DEPTH (MAX_GROUPS)
                ) u_ram (
                    .clk   (clk),
                    .we    (we),
                    .waddr (waddr),
                    .wdata (param_value),
                    .re    (data_accept),
                    .raddr (group_reg),
                    .rdata (tdata[t])
                );
            end

            bn8_lane u_lane (
                .clk       (clk),
                .ctrl      (ctrl),
                .x         (data_reg[8*l +: 8]),
                .in_scale  (input_scale_reg),
                .out_scale (output_scale_reg),
                .mean      (tdata[TBL_MEAN]),
                .inv_std   (tdata[TBL_INV_STD]),
                .gamma     (tdata[TBL_GAMMA]),
                .beta      (tdata[TBL_BETA]),
                .result    (lres)
            );
            assign lane_word[8*l +: 8] = lres;
        end
        else
        begin : g_unused
            assign lane_word[8*l +: 8] = 8'h00;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_lanes = result_reg;
    assign run_done     = run_done_reg;
endmodule
`default_nettype wire

// File: hw/rtl/bn8_checker.sv
// port-level checker for the int8 batch normalisation block, bound to the top
`default_nettype none
`include "assert_macros.svh"
module bn8_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        operation,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [63:0] result_lanes
);
    import bn8_pkg::*;

    `AST_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `AST_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(result_lanes))
    `AST_NEXT(a_data_busy, clk, rst_n, in_valid && !in_stall && (operation == OP_DATA), in_stall)
    `AST_NEXT(a_load_quick, clk, rst_n, in_valid && !in_stall && (operation == OP_LOAD), !in_stall)
endmodule

bind batch_norm_int8_lanes bn8_checker u_bn8_checker (.*);
`default_nettype wire
